// ===== hdl/pie_pkg.sv =====
// ============================================================================
// pie_pkg
// Shared types and constants for the positional insert/erase list.
// ============================================================================
package pie_pkg;

    // Fixed payload field widths
    localparam int MODE_W   = 2;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default storage shape
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_FULL  = 2'd3
    } t_status;

    // Command from controller to datapath, one strobe per operation
    typedef struct packed {
        logic             insert;
        logic             erase;
        logic             read;
        logic             clear;
        logic             accept;
        logic [POS_W-1:0] pos;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [COUNT_W-1:0] count;
    } t_dp_stat;

endpackage

// ===== hdl/pie_req_if.sv =====
// ============================================================================
// pie_req_if
// Request channel: operation, position and data word with valid/ready.
// ============================================================================
interface pie_req_if
    import pie_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data;

    modport source (output valid, output mode, output position, output data, input ready);
    modport sink   (input valid, input mode, input position, input data, output ready);
endinterface

// ===== hdl/pie_rsp_if.sv =====
// ============================================================================
// pie_rsp_if
// Response channel: status, read data and entry count with valid/ready.
// ============================================================================
interface pie_rsp_if
    import pie_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_data;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output read_data, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_data, input entry_count,
                    output ready);
endinterface

// ===== hdl/pie_datapath.sv =====
// ============================================================================
// pie_datapath
// Chain of entry cells with parallel shift up/down, read mux and count.
// ============================================================================
module pie_datapath
    import pie_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [WORD_W-1:0] i_data,
    output t_dp_stat          o_stat,
    output logic [WORD_W-1:0] o_read_data
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic [WORD_W-1:0]     r_read_data;
    logic [IDX_W-1:0]      w_idx;

    assign w_idx = i_cmd.pos[IDX_W-1:0];

    // Shift the cell chain: each cell takes its neighbor or the new word
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.insert) begin
                if (POS_W'(i) == i_cmd.pos) begin
                    r_cell[i] <= i_data[DATA_WIDTH-1:0];
                end else if (i > 0 && POS_W'(i) > i_cmd.pos) begin
                    r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.erase) begin
                if (i < CAPACITY - 1 && POS_W'(i) >= i_cmd.pos) begin
                    r_cell[i] <= r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Next entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.insert) begin
            n_count = r_count + COUNT_W'(1);
        end else if (i_cmd.erase) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Register read data on every command; zero unless a read succeeds
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_read_data <= WORD_W'(r_cell[w_idx]);
        end else if (i_cmd.accept) begin
            r_read_data <= '0;
        end
    end

    assign o_stat.count = r_count;
    assign o_read_data  = r_read_data;
endmodule

// ===== hdl/pie_ctrl.sv =====
// ============================================================================
// pie_ctrl
// Request decode, range/empty/full checks and response handshake control.
// ============================================================================
module pie_ctrl
    import pie_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [MODE_W-1:0]   i_req_mode,
    input  logic [POS_W-1:0]    i_req_pos,
    output logic                o_req_ready,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output logic [STATUS_W-1:0] o_rsp_status,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd
);
    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_status            r_status;
    t_status            n_status;
    logic               w_accept;
    logic               w_do;
    logic [COUNT_W-1:0] w_count;

    assign w_count     = i_stat.count;
    assign o_req_ready = (r_state == S_IDLE) || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;

    // Check the request against the count and pick the status
    always_comb begin
        n_status = STATUS_OK;
        w_do     = 1'b0;
        unique case (t_mode'(i_req_mode))
            MODE_INSERT: begin
                if (i_req_pos > w_count) begin
                    n_status = STATUS_RANGE;
                end else if (w_count >= COUNT_W'(CAPACITY)) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_do = 1'b1;
                end
            end
            MODE_ERASE, MODE_READ: begin
                if (w_count == '0) begin
                    n_status = STATUS_EMPTY;
                end else if (i_req_pos >= w_count) begin
                    n_status = STATUS_RANGE;
                end else begin
                    w_do = 1'b1;
                end
            end
            MODE_CLEAR: begin
                w_do = 1'b1;
            end
            default: begin
                w_do = 1'b0;
            end
        endcase
    end

    // Issue the datapath command only for an accepted item
    always_comb begin
        o_cmd.insert = w_accept && w_do && (t_mode'(i_req_mode) == MODE_INSERT);
        o_cmd.erase  = w_accept && w_do && (t_mode'(i_req_mode) == MODE_ERASE);
        o_cmd.clear  = w_accept && w_do && (t_mode'(i_req_mode) == MODE_CLEAR);
        // A successful read loads the entry, any other accepted item loads zero
        o_cmd.read   = w_accept && w_do && (t_mode'(i_req_mode) == MODE_READ);
        o_cmd.accept = w_accept;
        o_cmd.pos    = i_req_pos;
    end

    // Next state: hold a result until it is taken
    always_comb begin
        n_state = r_state;
        if (w_accept) begin
            n_state = S_RESULT;
        end else if (i_rsp_ready) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STATUS_OK;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_status <= n_status;
            end
        end
    end

    assign o_rsp_valid  = (r_state == S_RESULT);
    assign o_rsp_status = r_status;
endmodule

// ===== hdl/positional_insert_erase_list.sv =====
// ============================================================================
// positional_insert_erase_list
// Fixed-capacity ordered list with positional insert, erase, read and clear.
// ============================================================================
// Each request is checked against the entry count and executed in the cycle it
// is accepted: the entries sit in a chain of cells that all shift by one place
// at once, so an insert or erase costs the same whatever its position. The
// result (status, read data, new count) appears in the response register the
// cycle after acceptance and a new request is taken in the same cycle the
// previous result is taken (one request per clock when not stalled). Entries
// are not cleared by reset or a clear; only entries below the count are read.
module positional_insert_erase_list
    import pie_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pie_req_if.sink   i_req,
    pie_rsp_if.source o_rsp
);
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [WORD_W-1:0] w_read_data;

    pie_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_mode   (i_req.mode),
        .i_req_pos    (i_req.position),
        .o_req_ready  (i_req.ready),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp_status (o_rsp.status),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    pie_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data      (i_req.data),
        .o_stat      (w_stat),
        .o_read_data (w_read_data)
    );

    assign o_rsp.read_data   = w_read_data;
    assign o_rsp.entry_count = w_stat.count;
endmodule

// ===== tb/pie_list_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pie_list_checker
// Watches the request and response channels of the positional list, keeps
// its own copy of the entries and the count, and compares every response
// field by field with the oldest outstanding prediction.
// ============================================================================
module pie_list_checker
    import pie_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pie_req_if   i_req,
    pie_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [WORD_W-1:0] WORD_MASK =
        (DATA_WIDTH >= WORD_W) ? {WORD_W{1'b1}} : ({WORD_W{1'b1}} >> (WORD_W - DATA_WIDTH));

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  read_data;
        logic [COUNT_W-1:0] entry_count;
    } list_result_t;

    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_len;
    list_result_t      awaited_results [$];
    int                fail_total;

    // Apply one request to the shadow list and return the response it causes
    function automatic list_result_t apply_request(t_mode mode, logic [POS_W-1:0] pos,
                                                   logic [WORD_W-1:0] word);
        list_result_t res;
        int           p;
        p                 = int'(pos);
        res.status        = STATUS_OK;
        res.read_data     = '0;
        case (mode)
            MODE_INSERT: begin
                if (p > list_len) begin
                    res.status = STATUS_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
                    list_words[p] = word & WORD_MASK;
                    list_len++;
                end
            end
            MODE_ERASE: begin
                if (list_len == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (p >= list_len) begin
                    res.status = STATUS_RANGE;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (list_len == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (p >= list_len) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.read_data = list_words[p] & WORD_MASK;
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.entry_count = COUNT_W'(list_len);
        return res;
    endfunction

    // Retire responses first, then record the prediction for a new request
    always @(posedge i_clk) begin
        list_result_t exp_res;
        if (!i_rst_n) begin
            awaited_results.delete();
            list_len   = 0;
            fail_total = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("response with no request outstanding: status %0d data %h count %0d",
                           i_rsp.status, i_rsp.read_data, i_rsp.entry_count);
                    fail_total++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_rsp.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, i_rsp.status);
                        fail_total++;
                    end
                    if (i_rsp.read_data !== exp_res.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               exp_res.read_data, i_rsp.read_data);
                        fail_total++;
                    end
                    if (i_rsp.entry_count !== exp_res.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp_res.entry_count, i_rsp.entry_count);
                        fail_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                exp_res = apply_request(t_mode'(i_req.mode), i_req.position, i_req.data);
                awaited_results.insert(awaited_results.size(), exp_res);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives directed and random list requests into the positional list, with
// bursty request traffic and a stalling response side, and reports the
// verdict from the checker's failure count.
// ============================================================================
module tb_top;
    import pie_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1130;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int fill_level  = 0;

    pie_req_if req_if ();
    pie_rsp_if rsp_if ();

    positional_insert_erase_list #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DEF_DATA_WIDTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    pie_list_checker #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DEF_DATA_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one item, opening a gap first when the current burst is used up
    task automatic send_request(input t_mode mode, input int pos, input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.position <= POS_W'(pos);
        req_if.data     <= word;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // track the fill level to steer the random traffic
        case (mode)
            MODE_INSERT: if (pos <= fill_level && fill_level < CAPACITY) fill_level++;
            MODE_ERASE:  if (fill_level > 0 && pos < fill_level) fill_level--;
            MODE_CLEAR:  fill_level = 0;
            default: ;
        endcase
    endtask

    // Response side: segments of full rate, random stalls and hold-offs
    initial begin : rsp_stall_pattern
        int seg_idx;
        int seg_len;
        int kind;
        bit rdy;
        rsp_if.ready <= 1'b0;
        seg_idx = 0;
        forever begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(10, 60);
            // one long hold-off early on so the list backs up into the request side
            if (seg_idx == 4) begin
                kind    = 10;
                seg_len = 150;
            end else if (kind == 9) begin
                seg_len = $urandom_range(20, 50);
            end
            for (int c = 0; c < seg_len; c++) begin
                @(posedge i_clk);
                case (kind)
                    0, 1, 2, 3: rdy = 1'b1;
                    4, 5, 6:    rdy = ($urandom_range(0, 3) != 0);
                    7, 8:       rdy = $urandom_range(0, 1);
                    default:    rdy = 1'b0;
                endcase
                rsp_if.ready <= rdy;
            end
            seg_idx++;
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int          roll;
        int          pos;
        bit          grow;
        t_mode       mode;
        req_if.valid    <= 1'b0;
        req_if.mode     <= MODE_READ;
        req_if.position <= '0;
        req_if.data     <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-list corner cases
        send_request(MODE_READ, 0, 32'h1234_5678);
        send_request(MODE_ERASE, 0, '0);
        send_request(MODE_INSERT, 1, 32'hDEAD_BEEF);
        send_request(MODE_CLEAR, 16, 32'hFFFF_FFFF);

        // Fill to capacity: front insert, push-back, then random positions
        send_request(MODE_INSERT, 0, 32'h0000_0000);
        send_request(MODE_INSERT, 1, 32'hFFFF_FFFF);
        for (int i = 2; i < CAPACITY; i++)
            send_request(MODE_INSERT, $urandom_range(0, i), $urandom);

        // Full list, back read, pop-back, past-the-end read and erase, clear
        send_request(MODE_INSERT, 16, 32'hA5A5_A5A5);
        send_request(MODE_INSERT, 3, 32'h5A5A_5A5A);
        send_request(MODE_READ, 15, '0);
        send_request(MODE_READ, 0, '0);
        send_request(MODE_ERASE, 15, '0);
        send_request(MODE_READ, 16, '0);
        send_request(MODE_ERASE, 15, '0);
        send_request(MODE_ERASE, 4, '0);
        send_request(MODE_CLEAR, 7, '0);

        // Random traffic sweeping the fill level up and down
        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (fill_level == CAPACITY) grow = 1'b0;
            if (fill_level == 0) grow = 1'b1;
            if ($urandom_range(0, 19) == 0) grow = ~grow;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_request(MODE_CLEAR, $urandom_range(0, 16), $urandom);
            end else if (roll < 10) begin
                mode = t_mode'($urandom_range(0, 3));
                send_request(mode, $urandom_range(0, 16), $urandom);
            end else if (roll < 22) begin
                pos = (fill_level > 0) ? $urandom_range(0, fill_level - 1) : 0;
                send_request(MODE_READ, pos, $urandom);
            end else if (roll < 28) begin
                mode = t_mode'($urandom_range(0, 2));
                if (mode == MODE_INSERT)
                    pos = (fill_level == CAPACITY) ? 16 : $urandom_range(fill_level + 1, 16);
                else
                    pos = $urandom_range(fill_level, 16);
                send_request(mode, pos, $urandom);
            end else if (grow) begin
                // push-back, front insert or anywhere in between
                case ($urandom_range(0, 2))
                    0:       pos = fill_level;
                    1:       pos = 0;
                    default: pos = $urandom_range(0, fill_level);
                endcase
                send_request(MODE_INSERT, pos, $urandom);
            end else begin
                case ($urandom_range(0, 2))
                    0:       pos = (fill_level > 0) ? fill_level - 1 : 0;
                    1:       pos = 0;
                    default: pos = (fill_level > 0) ? $urandom_range(0, fill_level - 1) : 0;
                endcase
                send_request(MODE_ERASE, pos, $urandom);
            end
        end
        req_if.valid <= 1'b0;

        // Drain outstanding responses
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
